[src/hvn_pkg.sv]
// Shared constants, handshake structs and helpers of the heightfield vertex normal unit.
package hvn_pkg;

	localparam int MAX_SIDE_DEF = 256;
	localparam int CFG_W        = 9;
	localparam int IDX_W        = 16;
	localparam int SAMPLE_W     = 16;
	localparam int DIFF_W       = SAMPLE_W + 1;
	localparam int NRM_W        = 16;
	localparam int TEX_W        = 17;
	localparam int ACC_W        = 24;
	localparam int PROD_W       = 2 * ACC_W;
	localparam int CALC_AW      = 18;
	localparam int ROOT_IN_W    = 62;
	localparam int ROOT_W       = ROOT_IN_W / 2;
	localparam int DIV_QW       = 22;
	localparam int DIV_DW       = 32;
	localparam int DIV_NW       = DIV_DW + DIV_QW - 1;
	localparam int NRM_ONE      = 16384;
	localparam int HEIGHT_SCALE = 10;
	localparam int HEIGHT_SQ    = HEIGHT_SCALE * HEIGHT_SCALE;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_ROWS    = 1'b1;

	typedef struct packed {
		logic              go;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_QW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic                 go;
		logic [ROOT_IN_W-1:0] arg;
	} root_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;

	function automatic logic signed [DIFF_W-1:0] sdiff(input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic [SAMPLE_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
		logic [DIFF_W-1:0] t;
		t = v[DIFF_W-1] ? 17'(-v) : 17'(v);
		return t[SAMPLE_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? 24'(-v) : 24'(v);
	endfunction

endpackage

[src/heightfield_vertex_normal_unit.sv]
// Heightfield vertex normal unit: sample store, sequencer and shared arithmetic.
//
// Usage. The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// grid width and height; it is always ready, and the user must write it only
// while the unit is idle: the block itself does not enforce this. The input
// channel carries one command per beat: a load writes height_sample at
// vertex_index and gives no result; a read returns one result beat with the
// unit normal (Q1.14) and texture coordinates (Q1.16, unsigned) of that vertex.
// Commands whose index lies outside the grid are dropped. A read runs on the
// single shared divider and square-root unit, so a border vertex, with fewer
// adjacent triangles, finishes sooner; the root unit is used once per triangle
// and once more for the final normalisation, the divider once per component.
// The input is accepted only between commands, but a finished result sits in an
// output register, so the next command is taken while the receiver stalls; a
// second result waits in the sequencer until that register is free.
// Reset clears the sequencer, the output register and the grid size (256 by 256);
// the sample memory is not cleared and every sample must be loaded before it is
// used by a read.
module heightfield_vertex_normal_unit #(
	parameter int MAX_SIDE = hvn_pkg::MAX_SIDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [hvn_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  hvn_pkg::cmd_t                     command,
	input  logic [hvn_pkg::IDX_W-1:0]         vertex_index,
	input  logic [hvn_pkg::SAMPLE_W-1:0]      height_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hvn_pkg::IDX_W-1:0]         out_index,
	output logic signed [hvn_pkg::NRM_W-1:0]  normal_x,
	output logic signed [hvn_pkg::NRM_W-1:0]  normal_y,
	output logic signed [hvn_pkg::NRM_W-1:0]  normal_z,
	output logic [hvn_pkg::TEX_W-1:0]         tex_u,
	output logic [hvn_pkg::TEX_W-1:0]         tex_v
);
	import hvn_pkg::*;

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);

	// sample slots around the vertex
	localparam logic [2:0] SMP_C   = 3'd0;
	localparam logic [2:0] SMP_N   = 3'd1;
	localparam logic [2:0] SMP_NE  = 3'd2;
	localparam logic [2:0] SMP_W   = 3'd3;
	localparam logic [2:0] SMP_E   = 3'd4;
	localparam logic [2:0] SMP_SW  = 3'd5;
	localparam logic [2:0] SMP_S   = 3'd6;
	localparam logic [2:0] SMP_END = 3'd7;

	// adjacent triangles: upper-right cell A and B, upper-left A, lower-left A and B,
	// lower-right B
	localparam logic [2:0] FC_A_UR = 3'd0;
	localparam logic [2:0] FC_B_UR = 3'd1;
	localparam logic [2:0] FC_A_UL = 3'd2;
	localparam logic [2:0] FC_A_LL = 3'd3;
	localparam logic [2:0] FC_B_LL = 3'd4;
	localparam logic [2:0] FC_B_LR = 3'd5;

	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RC, ST_FETCH, ST_FACE, ST_SQ_DX, ST_SQ_DZ, ST_SQ_SUM, ST_ROOT,
		ST_CGO, ST_CDIV, ST_NSQ_X, ST_NSQ_Y, ST_NSQ_Z, ST_NSQ_SUM, ST_NROOT,
		ST_NGO, ST_NDIV, ST_TEX_U, ST_TEX_V, ST_FINISH
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] cols_q, rows_q;
	logic [CFG_W-1:0] w_eff, h_eff, wm1, hm1;
	logic [CALC_AW-1:0] area;
	logic in_range;

	logic [IDX_W-1:0] idx_q;
	logic [CFG_W-1:0] r_q, c_q;
	logic up_q, dn_q, lf_q, rt_q;
	logic [2:0] fk_q, face_q;
	logic [1:0] comp_q;
	logic [SAMPLE_W-1:0] h_q [7];
	logic signed [DIFF_W-1:0] dx_q, dz_q;
	logic [PROD_W-1:0] prod_q, sum_q, sum_next;
	logic [ROOT_W-1:0] s_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic [TEX_W-1:0] tu_q, tv_q;

	logic out_valid_q;
	logic [IDX_W-1:0] out_index_q;
	logic signed [NRM_W-1:0] out_nx_q, out_ny_q, out_nz_q;
	logic [TEX_W-1:0] out_tu_q, out_tv_q;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	root_req_t root_req;
	root_rsp_t root_rsp;
	logic div_go_q, root_go_q;
	logic [DIV_NW-1:0] div_num_q;
	logic [DIV_DW-1:0] div_den_q;
	logic [ROOT_IN_W-1:0] root_arg_q;

	logic ram_we;
	logic [SAMPLE_W-1:0] rd_data;
	logic [CALC_AW-1:0] fetch_addr, idx18, w18;

	logic face_en;
	logic signed [DIFF_W-1:0] face_dx, face_dz;
	logic signed [ACC_W-1:0] mul_a;
	logic signed [PROD_W-1:0] mul_p;
	logic [SAMPLE_W-1:0] cmag;
	logic cneg;
	logic signed [ACC_W-1:0] acc_sel;
	logic [ACC_W-1:0] amag;
	logic signed [ACC_W-1:0] qsigned;
	logic [NRM_W-1:0] nsat;
	logic signed [NRM_W-1:0] nval;
	logic [CFG_W:0] r_inc, c_inc;

	// grid size, clamped to the legal range
	always_comb begin
		if (cols_q < CFG_W'(2))
			w_eff = CFG_W'(2);
		else if (int'(cols_q) > MAX_SIDE)
			w_eff = CFG_W'(MAX_SIDE);
		else
			w_eff = cols_q;
		if (rows_q < CFG_W'(2))
			h_eff = CFG_W'(2);
		else if (int'(rows_q) > MAX_SIDE)
			h_eff = CFG_W'(MAX_SIDE);
		else
			h_eff = rows_q;
	end

	assign wm1      = w_eff - 1'b1;
	assign hm1      = h_eff - 1'b1;
	assign area     = CALC_AW'(w_eff) * CALC_AW'(h_eff);
	assign in_range = CALC_AW'(vertex_index) < area;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_W'(MAX_SIDE_DEF);
			rows_q <= CFG_W'(MAX_SIDE_DEF);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COLUMNS: cols_q <= cfg_data;
				CFG_ROWS:    rows_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign ram_we   = in_valid && in_ready && (command == CMD_LOAD) && in_range;

	assign idx18 = CALC_AW'(idx_q);
	assign w18   = CALC_AW'(w_eff);

	always_comb begin
		case (fk_q)
			SMP_N:   fetch_addr = idx18 - w18;
			SMP_NE:  fetch_addr = idx18 - w18 + 1'b1;
			SMP_W:   fetch_addr = idx18 - 1'b1;
			SMP_E:   fetch_addr = idx18 + 1'b1;
			SMP_SW:  fetch_addr = idx18 + w18 - 1'b1;
			SMP_S:   fetch_addr = idx18 + w18;
			default: fetch_addr = idx18;
		endcase
	end

	hvn_height_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(CALC_AW'(vertex_index))),
		.wdata   (height_sample),
		.raddr   (AW'(fetch_addr)),
		.rd_data (rd_data)
	);

	assign div_req.go   = div_go_q;
	assign div_req.num  = div_num_q;
	assign div_req.den  = div_den_q;
	assign root_req.go  = root_go_q;
	assign root_req.arg = root_arg_q;

	hvn_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hvn_isqrt u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	// edge vectors of the current triangle
	always_comb begin
		face_en = 1'b0;
		face_dx = '0;
		face_dz = '0;
		case (face_q)
			FC_A_UR: begin
				face_en = up_q && rt_q;
				face_dx = sdiff(h_q[SMP_C], h_q[SMP_E]);
				face_dz = sdiff(h_q[SMP_NE], h_q[SMP_E]);
			end
			FC_B_UR: begin
				face_en = up_q && rt_q;
				face_dx = sdiff(h_q[SMP_N], h_q[SMP_NE]);
				face_dz = sdiff(h_q[SMP_N], h_q[SMP_C]);
			end
			FC_A_UL: begin
				face_en = up_q && lf_q;
				face_dx = sdiff(h_q[SMP_W], h_q[SMP_C]);
				face_dz = sdiff(h_q[SMP_N], h_q[SMP_C]);
			end
			FC_A_LL: begin
				face_en = dn_q && lf_q;
				face_dx = sdiff(h_q[SMP_SW], h_q[SMP_S]);
				face_dz = sdiff(h_q[SMP_C], h_q[SMP_S]);
			end
			FC_B_LL: begin
				face_en = dn_q && lf_q;
				face_dx = sdiff(h_q[SMP_W], h_q[SMP_C]);
				face_dz = sdiff(h_q[SMP_W], h_q[SMP_SW]);
			end
			FC_B_LR: begin
				face_en = dn_q && rt_q;
				face_dx = sdiff(h_q[SMP_C], h_q[SMP_E]);
				face_dz = sdiff(h_q[SMP_C], h_q[SMP_S]);
			end
			default: ;
		endcase
	end

	// one squarer, product registered
	always_comb begin
		case (state_q)
			ST_SQ_DX: mul_a = ACC_W'(dx_q);
			ST_SQ_DZ: mul_a = ACC_W'(dz_q);
			ST_NSQ_X: mul_a = acc_x_q;
			ST_NSQ_Y: mul_a = acc_y_q;
			ST_NSQ_Z: mul_a = acc_z_q;
			default:  mul_a = '0;
		endcase
	end

	assign mul_p    = mul_a * mul_a;
	assign sum_next = sum_q + prod_q;

	always_comb begin
		case (comp_q)
			COMP_X: begin
				cmag    = mag_diff(dx_q);
				cneg    = dx_q[DIFF_W-1];
				acc_sel = acc_x_q;
			end
			COMP_Y: begin
				cmag    = SAMPLE_W'(HEIGHT_SCALE);
				cneg    = 1'b0;
				acc_sel = acc_y_q;
			end
			default: begin
				cmag    = mag_diff(dz_q);
				cneg    = dz_q[DIFF_W-1];
				acc_sel = acc_z_q;
			end
		endcase
	end

	assign amag    = mag_acc(acc_sel);
	assign qsigned = cneg ? -$signed(ACC_W'(div_rsp.quo)) : $signed(ACC_W'(div_rsp.quo));
	assign nsat    = (div_rsp.quo > DIV_QW'(NRM_ONE)) ? NRM_W'(NRM_ONE)
		: div_rsp.quo[NRM_W-1:0];
	assign nval    = acc_sel[ACC_W-1] ? -$signed(nsat) : $signed(nsat);
	assign r_inc   = {1'b0, div_rsp.quo[CFG_W-1:0]} + 1'b1;
	assign c_inc   = {1'b0, div_rsp.rem[CFG_W-1:0]} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			up_q        <= 1'b0;
			dn_q        <= 1'b0;
			lf_q        <= 1'b0;
			rt_q        <= 1'b0;
			fk_q        <= '0;
			face_q      <= '0;
			comp_q      <= '0;
			for (int i = 0; i < 7; i++)
				h_q[i] <= '0;
			dx_q        <= '0;
			dz_q        <= '0;
			prod_q      <= '0;
			sum_q       <= '0;
			s_q         <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_z_q     <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			nz_q        <= '0;
			tu_q        <= '0;
			tv_q        <= '0;
			div_go_q    <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			root_go_q   <= 1'b0;
			root_arg_q  <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_nx_q    <= '0;
			out_ny_q    <= '0;
			out_nz_q    <= '0;
			out_tu_q    <= '0;
			out_tv_q    <= '0;
		end else begin
			div_go_q  <= 1'b0;
			root_go_q <= 1'b0;
			prod_q    <= PROD_W'(mul_p);
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && command == CMD_READ && in_range) begin
						idx_q     <= vertex_index;
						div_go_q  <= 1'b1;
						div_num_q <= DIV_NW'(vertex_index);
						div_den_q <= DIV_DW'(w_eff);
						state_q   <= ST_RC;
					end
				end
				ST_RC: begin
					if (div_rsp.done) begin
						r_q     <= div_rsp.quo[CFG_W-1:0];
						c_q     <= div_rsp.rem[CFG_W-1:0];
						up_q    <= div_rsp.quo[CFG_W-1:0] != '0;
						lf_q    <= div_rsp.rem[CFG_W-1:0] != '0;
						dn_q    <= r_inc < {1'b0, h_eff};
						rt_q    <= c_inc < {1'b0, w_eff};
						fk_q    <= SMP_C;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// read data arrives in the cycle after its address
					if (fk_q != SMP_C)
						h_q[fk_q - 1'b1] <= rd_data;
					if (fk_q == SMP_END) begin
						face_q  <= FC_A_UR;
						acc_x_q <= '0;
						acc_y_q <= '0;
						acc_z_q <= '0;
						state_q <= ST_FACE;
					end else begin
						fk_q <= fk_q + 1'b1;
					end
				end
				ST_FACE: begin
					if (face_en) begin
						dx_q    <= face_dx;
						dz_q    <= face_dz;
						state_q <= ST_SQ_DX;
					end else if (face_q == FC_B_LR) begin
						state_q <= ST_NSQ_X;
					end else begin
						face_q <= face_q + 1'b1;
					end
				end
				ST_SQ_DX: state_q <= ST_SQ_DZ;
				ST_SQ_DZ: begin
					sum_q   <= prod_q + PROD_W'(HEIGHT_SQ);
					state_q <= ST_SQ_SUM;
				end
				ST_SQ_SUM: begin
					root_arg_q <= ROOT_IN_W'({sum_next[33:0], 28'b0});
					root_go_q  <= 1'b1;
					state_q    <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_rsp.done) begin
						s_q     <= root_rsp.root;
						comp_q  <= COMP_X;
						state_q <= ST_CGO;
					end
				end
				ST_CGO: begin
					// rounded quotient: (2|a| + s) / 2s, a = component * 2^34
					div_go_q  <= 1'b1;
					div_num_q <= DIV_NW'({cmag, 35'b0}) + DIV_NW'(s_q);
					div_den_q <= {s_q, 1'b0};
					state_q   <= ST_CDIV;
				end
				ST_CDIV: begin
					if (div_rsp.done) begin
						case (comp_q)
							COMP_X:  acc_x_q <= acc_x_q + qsigned;
							COMP_Y:  acc_y_q <= acc_y_q + qsigned;
							default: acc_z_q <= acc_z_q + qsigned;
						endcase
						if (comp_q == COMP_Z) begin
							if (face_q == FC_B_LR) begin
								state_q <= ST_NSQ_X;
							end else begin
								face_q  <= face_q + 1'b1;
								state_q <= ST_FACE;
							end
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= ST_CGO;
						end
					end
				end
				ST_NSQ_X: state_q <= ST_NSQ_Y;
				ST_NSQ_Y: begin
					sum_q   <= prod_q;
					state_q <= ST_NSQ_Z;
				end
				ST_NSQ_Z: begin
					sum_q   <= sum_next;
					state_q <= ST_NSQ_SUM;
				end
				ST_NSQ_SUM: begin
					root_arg_q <= ROOT_IN_W'({sum_next, 14'b0});
					root_go_q  <= 1'b1;
					state_q    <= ST_NROOT;
				end
				ST_NROOT: begin
					if (root_rsp.done) begin
						s_q <= root_rsp.root;
						if (root_rsp.root == '0) begin
							// degenerate sum: straight up
							nx_q      <= '0;
							ny_q      <= NRM_W'(NRM_ONE);
							nz_q      <= '0;
							div_go_q  <= 1'b1;
							div_num_q <= DIV_NW'({c_q, 17'b0}) + DIV_NW'(wm1);
							div_den_q <= DIV_DW'({wm1, 1'b0});
							state_q   <= ST_TEX_U;
						end else begin
							comp_q  <= COMP_X;
							state_q <= ST_NGO;
						end
					end
				end
				ST_NGO: begin
					div_go_q  <= 1'b1;
					div_num_q <= DIV_NW'({amag, 22'b0}) + DIV_NW'(s_q);
					div_den_q <= {s_q, 1'b0};
					state_q   <= ST_NDIV;
				end
				ST_NDIV: begin
					if (div_rsp.done) begin
						case (comp_q)
							COMP_X:  nx_q <= nval;
							COMP_Y:  ny_q <= nval;
							default: nz_q <= nval;
						endcase
						if (comp_q == COMP_Z) begin
							div_go_q  <= 1'b1;
							div_num_q <= DIV_NW'({c_q, 17'b0}) + DIV_NW'(wm1);
							div_den_q <= DIV_DW'({wm1, 1'b0});
							state_q   <= ST_TEX_U;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= ST_NGO;
						end
					end
				end
				ST_TEX_U: begin
					if (div_rsp.done) begin
						tu_q      <= div_rsp.quo[TEX_W-1:0];
						div_go_q  <= 1'b1;
						div_num_q <= DIV_NW'({r_q, 17'b0}) + DIV_NW'(hm1);
						div_den_q <= DIV_DW'({hm1, 1'b0});
						state_q   <= ST_TEX_V;
					end
				end
				ST_TEX_V: begin
					if (div_rsp.done) begin
						tv_q    <= div_rsp.quo[TEX_W-1:0];
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_index_q <= idx_q;
						out_nx_q    <= nx_q;
						out_ny_q    <= ny_q;
						out_nz_q    <= nz_q;
						out_tu_q    <= tu_q;
						out_tv_q    <= tv_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign normal_x  = out_nx_q;
	assign normal_y  = out_ny_q;
	assign normal_z  = out_nz_q;
	assign tex_u     = out_tu_q;
	assign tex_v     = out_tv_q;

endmodule

[src/hvn_height_ram.sv]
// Height sample memory: one write port, one registered read port.
module hvn_height_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [hvn_pkg::SAMPLE_W-1:0]  wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [hvn_pkg::SAMPLE_W-1:0]  rd_data
);
	import hvn_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_data_q <= mem[raddr];
	end

	assign rd_data = rd_data_q;

endmodule

[src/hvn_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
module hvn_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  hvn_pkg::root_req_t req,
	output hvn_pkg::root_rsp_t rsp
);
	import hvn_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	logic [ROOT_IN_W-1:0] arg_q;
	logic [ROOT_W+1:0]    rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ROOT_W+3:0]    rem_next;
	logic [ROOT_W+3:0]    trial;

	// bring down two bits, try the next root bit
	assign rem_next = {rem_q, arg_q[ROOT_IN_W-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				arg_q  <= req.arg;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(ROOT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				arg_q <= {arg_q[ROOT_IN_W-3:0], 2'b00};
				if (rem_next >= trial) begin
					rem_q  <= (ROOT_W+2)'(rem_next - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= (ROOT_W+2)'(rem_next);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

[src/hvn_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
module hvn_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  hvn_pkg::div_req_t req,
	output hvn_pkg::div_rsp_t rsp
);
	import hvn_pkg::*;

	localparam int CNT_W = $clog2(DIV_QW);

	logic [DIV_NW-1:0] rem_q;
	logic [DIV_NW-1:0] dsh_q;
	logic [DIV_QW-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				rem_q  <= req.num;
				dsh_q  <= {req.den, {(DIV_QW-1){1'b0}}};
				quo_q  <= '0;
				cnt_q  <= CNT_W'(DIV_QW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[DIV_QW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[DIV_QW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[DIV_DW-1:0];

endmodule

[src/hvn_checker.sv]
// Port-level checks of the heightfield vertex normal unit, bound to the top level.
module hvn_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [15:0]         out_index,
	input logic signed [15:0]  normal_x,
	input logic signed [15:0]  normal_y,
	input logic signed [15:0]  normal_z,
	input logic [16:0]         tex_u,
	input logic [16:0]         tex_v
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(normal_y))
		else $error("result beat changed while stalled");

	a_nrm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
			normal_y >= -16'sd16384 && normal_y <= 16'sd16384 &&
			normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
		else $error("normal component out of range");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
		else $error("texture coordinate out of range");

	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result beat present on leaving reset");

endmodule

bind heightfield_vertex_normal_unit hvn_checker u_hvn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_index (out_index),
	.normal_x  (normal_x),
	.normal_y  (normal_y),
	.normal_z  (normal_z),
	.tex_u     (tex_u),
	.tex_v     (tex_v)
);

[test/tb_heightfield_vertex_normal_unit.sv]
// Self-checking testbench for the heightfield vertex normal unit.
`timescale 1ns / 1ps

module tb_heightfield_vertex_normal_unit;
	import hvn_pkg::*;

	localparam int  SIDE_MAX    = 256;
	localparam int  DEPTH       = SIDE_MAX * SIDE_MAX;
	localparam int  RANDOM_ITEMS = 1800;
	localparam longint CYCLE_LIMIT = 6000000;
	localparam int  SETTLE      = 40;

	typedef struct {
		logic [15:0]        index;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [16:0]        u;
		logic [16:0]        v;
	} vertex_attr_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	cmd_t        command;
	logic [15:0] vertex_index;
	logic [15:0] height_sample;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] out_index;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [16:0] tex_u, tex_v;

	heightfield_vertex_normal_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.vertex_index(vertex_index), .height_sample(height_sample),
		.out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.tex_u(tex_u), .tex_v(tex_v)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [15:0]  heights [DEPTH];
	logic [8:0]   columns_reg, rows_reg;
	vertex_attr_t pending_normals [$];
	int           fail_count;
	int           items_sent;
	bit           idle_on;
	longint       cycle_count;

	// ---------------- predictor ----------------
	function automatic int side_of(logic [8:0] v);
		if (v < 2) return 2;
		if (v > SIDE_MAX) return SIDE_MAX;
		return int'(v);
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_div(longint a, longint unsigned d);
		longint unsigned m, q;
		m = (a < 0) ? longint'(-a) : a;
		q = (2 * m + d) / (2 * d);
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint height_at(int w, int r, int c);
		int idx;
		idx = r * w + c;
		if (idx >= DEPTH) return 0;
		return longint'(heights[idx]);
	endfunction

	function automatic void add_face(longint dx, longint dz, inout longint acc [3]);
		longint unsigned len2, s;
		len2 = longint'(dx * dx) + longint'(dz * dz) + 100;
		s = root64(len2 << 28);
		if (s == 0) return;
		acc[0] += round_div(dx * (longint'(1) << 34), s);
		acc[1] += round_div(10 * (longint'(1) << 34), s);
		acc[2] += round_div(dz * (longint'(1) << 34), s);
	endfunction

	// lower-right triangle of cell (a, b)
	function automatic void tri_lower(int w, int a, int b, inout longint acc [3]);
		longint h11;
		h11 = height_at(w, a + 1, b + 1);
		add_face(height_at(w, a + 1, b) - h11, height_at(w, a, b + 1) - h11, acc);
	endfunction

	// upper-left triangle of cell (a, b)
	function automatic void tri_upper(int w, int a, int b, inout longint acc [3]);
		longint h00;
		h00 = height_at(w, a, b);
		add_face(h00 - height_at(w, a, b + 1), h00 - height_at(w, a + 1, b), acc);
	endfunction

	function automatic logic [15:0] unit_comp(longint comp, longint unsigned s);
		longint n;
		n = round_div(comp * (longint'(1) << 21), s);
		if (n > NRM_ONE) n = NRM_ONE;
		if (n < -NRM_ONE) n = -NRM_ONE;
		return n[15:0];
	endfunction

	function automatic vertex_attr_t vertex_normal(int idx);
		vertex_attr_t e;
		longint acc [3];
		longint unsigned len2, s;
		int w, h, r, c;
		w = side_of(columns_reg);
		h = side_of(rows_reg);
		acc = '{0, 0, 0};
		r = idx / w;
		c = idx % w;
		if (r >= 1 && c <= w - 2) begin
			tri_lower(w, r - 1, c, acc);
			tri_upper(w, r - 1, c, acc);
		end
		if (r >= 1 && c >= 1) tri_lower(w, r - 1, c - 1, acc);
		if (r <= h - 2 && c >= 1) begin
			tri_lower(w, r, c - 1, acc);
			tri_upper(w, r, c - 1, acc);
		end
		if (r <= h - 2 && c <= w - 2) tri_upper(w, r, c, acc);
		len2 = acc[0] * acc[0] + acc[1] * acc[1] + acc[2] * acc[2];
		s = root64(len2 << 14);
		e.index = idx[15:0];
		if (s == 0) begin
			e.nx = 0;
			e.ny = NRM_ONE;
			e.nz = 0;
		end else begin
			e.nx = unit_comp(acc[0], s);
			e.ny = unit_comp(acc[1], s);
			e.nz = unit_comp(acc[2], s);
		end
		e.u = 17'(((longint'(c) << 17) + (w - 1)) / (2 * (w - 1)));
		e.v = 17'(((longint'(r) << 17) + (h - 1)) / (2 * (h - 1)));
		return e;
	endfunction

	// ---------------- drivers ----------------
	task automatic send_command(cmd_t cmd, int idx, logic [15:0] sample);
		int cells;
		if (idle_on && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		vertex_index  <= idx[15:0];
		height_sample <= sample;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		cells = side_of(columns_reg) * side_of(rows_reg);
		if (idx < cells) begin
			if (cmd == CMD_LOAD)
				heights[idx] = sample;
			else
				pending_normals.push_back(vertex_normal(idx));
		end
	endtask

	// hold the input, wait for every result, then let a dropped read finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic which, logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (which == CFG_COLUMNS)
			columns_reg = value;
		else
			rows_reg = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid(logic [8:0] cols, logic [8:0] rows);
		write_reg(CFG_COLUMNS, cols);
		write_reg(CFG_ROWS, rows);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 40));
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !idle_on || ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin
		vertex_attr_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_normals.size() == 0) begin
				$error("result beat with nothing expected, index %0d", out_index);
				fail_count++;
			end else begin
				e = pending_normals.pop_front();
				if (out_index !== e.index) begin
					$error("out_index expected %0d actual %0d", e.index, out_index);
					fail_count++;
				end
				if (normal_x !== e.nx) begin
					$error("normal_x expected %0d actual %0d", e.nx, normal_x);
					fail_count++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y expected %0d actual %0d", e.ny, normal_y);
					fail_count++;
				end
				if (normal_z !== e.nz) begin
					$error("normal_z expected %0d actual %0d", e.nz, normal_z);
					fail_count++;
				end
				if (tex_u !== e.u) begin
					$error("tex_u expected %0d actual %0d", e.u, tex_u);
					fail_count++;
				end
				if (tex_v !== e.v) begin
					$error("tex_v expected %0d actual %0d", e.v, tex_v);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- tests ----------------
	// full-size grid after reset: corners and one interior vertex
	task automatic test_reset_grid();
		int corner [] = '{0, 1, 256, 257, 2, 258, 512, 513, 514,
			65278, 65279, 65534, 65535};
		foreach (corner[i]) send_command(CMD_LOAD, corner[i], pick_sample());
		send_command(CMD_READ, 0, 16'h0000);
		send_command(CMD_READ, 257, 16'hFFFF);
		send_command(CMD_READ, 65535, 16'h0000);
		drain();
	endtask

	// smallest grid, extreme slopes, out-of-grid commands
	task automatic test_tiny_grid();
		set_grid(9'd2, 9'd2);
		send_command(CMD_LOAD, 0, 16'hFFFF);
		send_command(CMD_LOAD, 1, 16'h0000);
		send_command(CMD_LOAD, 2, 16'h0000);
		send_command(CMD_LOAD, 3, 16'hFFFF);
		send_command(CMD_LOAD, 4, 16'h1234);
		send_command(CMD_LOAD, 65535, 16'hAAAA);
		for (int i = 0; i < 4; i++) send_command(CMD_READ, i, 16'h5555);
		send_command(CMD_READ, 4, 16'h0000);
		send_command(CMD_READ, 65535, 16'h0000);
		send_command(CMD_LOAD, 0, 16'h0000);
		send_command(CMD_LOAD, 3, 16'h0000);
		send_command(CMD_READ, 0, 16'h0000);
		drain();
	endtask

	// register values outside the legal range saturate
	task automatic test_register_limits();
		logic [8:0] vals [4] = '{9'd0, 9'd1, 9'd257, 9'd511};
		foreach (vals[i]) begin
			set_grid(vals[i], vals[3 - i]);
			// neighbours of vertex 255 in either grid shape
			for (int k = 252; k < 260; k++) send_command(CMD_LOAD, k, pick_sample());
			send_command(CMD_LOAD, 510, pick_sample());
			send_command(CMD_LOAD, 511, pick_sample());
			send_command(CMD_READ, 65535, 16'h0000);
			send_command(CMD_READ, 0, 16'h0000);
			send_command(CMD_READ, 255, 16'h0000);
			drain();
		end
	endtask

	task automatic test_random_grids();
		int phase, w, h, cells, idx;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			idle_on = (phase % 8) != 3;
			case ($urandom_range(0, 9))
				0: set_grid(9'($urandom_range(0, 1)), 9'($urandom_range(2, 9)));
				1: set_grid(9'($urandom_range(2, 9)), 9'($urandom_range(257, 511)));
				default: set_grid(9'($urandom_range(2, 12)), 9'($urandom_range(2, 12)));
			endcase
			w = side_of(columns_reg);
			h = side_of(rows_reg);
			cells = w * h;
			if (cells > 200) begin
				// tall grid: keep to the first rows only
				for (int i = 0; i < 3 * w; i++) send_command(CMD_LOAD, i, pick_sample());
				for (int i = 0; i < 8; i++)
					send_command(CMD_READ, $urandom_range(0, w - 1), 16'($urandom));
			end else begin
				for (int i = 0; i < cells; i++) send_command(CMD_LOAD, i, pick_sample());
				for (int i = 0; i < 14; i++) begin
					idx = $urandom_range(0, cells - 1);
					case ($urandom_range(0, 9))
						0: send_command(CMD_LOAD, idx, pick_sample());
						1: send_command(cmd_t'($urandom_range(0, 1)),
							$urandom_range(cells, 65535), 16'($urandom));
						default: send_command(CMD_READ, idx, 16'($urandom));
					endcase
				end
			end
			drain();
			phase++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_COLUMNS;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		command       <= CMD_LOAD;
		vertex_index  <= '0;
		height_sample <= '0;
		columns_reg   = 9'd256;
		rows_reg      = 9'd256;
		fail_count    = 0;
		items_sent    = 0;
		cycle_count   = 0;
		idle_on       = 1'b1;
		foreach (heights[i]) heights[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_grid();
		test_tiny_grid();
		test_register_limits();
		test_random_grids();
		drain();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
